// ===== hw/rtl/mlft_pkg.sv =====
// shared types and constants of the mac learning forwarding table
`timescale 1ns / 1ps

package mlft_pkg;

  // field widths
  localparam int MacW      = 48;
  localparam int ItemPortW = 8;

  // all-ones address is broadcast
  localparam logic [MacW-1:0] MacBcast = {MacW{1'b1}};

  // action codes
  localparam logic ActFrame  = 1'b0;
  localparam logic ActExpire = 1'b1;

  // register index of table_ready (paddr bit 2)
  localparam logic RegTableReady = 1'b0;

  // learn status codes
  typedef enum logic [2:0] {
    StSame     = 3'd0,
    StLearned  = 3'd1,
    StFull     = 3'd2,
    StConflict = 3'd3,
    StBcastSrc = 3'd4,
    StNotReady = 3'd5
  } learn_status_e;

  // input item
  typedef struct packed {
    logic                 action;
    logic [ItemPortW-1:0] ingress_port;
    logic [MacW-1:0]      source_mac;
    logic [MacW-1:0]      dest_mac;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                 flood;
    logic [ItemPortW-1:0] egress_port;
    learn_status_e        learn_status;
    logic                 removed;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    CtlIdle,
    CtlScan,
    CtlDrain,
    CtlCommit
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mac_learning_forward_table_top.sv =====
// top level of the mac learning forwarding table
`timescale 1ns / 1ps

// Layer-2 learning table of TABLE_DEPTH slots. A frame item looks up its
// destination address and returns the learned port, or flood for broadcast
// or unknown destinations, then learns its source address against the
// ingress port in the lowest free slot; an expiry item forgets one address.
// The slots live in a single-port-read ram that is scanned one slot per
// cycle, so each item passes through an accept step, a read of every slot,
// a last compare and a commit. The result register lets the next item be
// accepted while a result still waits; if that result is still stalled when
// the next item reaches its commit step, the commit waits until the result
// is taken.
// table_ready sits at byte address 0 of the apb port.

module mac_learning_forward_table_top import mlft_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int PORT_BITS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      table_ready_q, table_ready_d;
  logic      cfg_wr;

  // apb register
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == RegTableReady);
  assign table_ready_d = cfg_wr ? pwdata[0] : table_ready_q;
  assign prdata        = (paddr[2] == RegTableReady) ? {31'b0, table_ready_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_ready_q <= 1'b0;
    end else begin
      table_ready_q <= table_ready_d;
    end
  end

  mlft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mlft_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PORT_BITS   (PORT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_item_i     (in_item_i),
    .table_ready_i (table_ready_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o)
  );

endmodule

// ===== hw/rtl/mlft_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mlft_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mlft_ctrl.sv =====
// controller state machine sequencing load, slot scan and commit
`timescale 1ns / 1ps

module mlft_ctrl import mlft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtlIdle: begin
        if (in_valid_i) begin
          state_d = CtlScan;
        end
      end
      CtlScan: begin
        if (stat_i.scan_last) begin
          state_d = CtlDrain;
        end
      end
      CtlDrain: begin
        state_d = CtlCommit;
      end
      CtlCommit: begin
        if (!stat_i.out_busy) begin
          state_d = CtlIdle;
        end
      end
      default: begin
        state_d = CtlIdle;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    unique case (state_q)
      CtlIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      CtlScan: begin
        cmd_o.scan = 1'b1;
      end
      CtlDrain: begin
        cmd_o = '0;
      end
      CtlCommit: begin
        cmd_o.commit = !stat_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/mlft_dp.sv =====
// datapath: slot store, scan compare, learn and forget, result register
`timescale 1ns / 1ps

module mlft_dp import mlft_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int PORT_BITS   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  input  in_item_t  in_item_i,
  input  logic      table_ready_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EntW = MacW + PORT_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  // item and scan registers
  in_item_t             item_q, item_d;
  logic [IdxW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic                 cmp_en_q, cmp_en_d;

  // scan accumulators
  logic                 dst_hit_q, dst_hit_d;
  logic [PORT_BITS-1:0] dst_port_q, dst_port_d;
  logic                 src_hit_q, src_hit_d;
  logic [IdxW-1:0]      src_idx_q, src_idx_d;
  logic [PORT_BITS-1:0] src_port_q, src_port_d;
  logic                 free_hit_q, free_hit_d;
  logic [IdxW-1:0]      free_idx_q, free_idx_d;

  // table valid bits and result register
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  // ram ports
  logic                 ram_we;
  logic [EntW-1:0]      ram_wdata;
  logic [EntW-1:0]      ram_rdata;
  logic [MacW-1:0]      slot_mac;
  logic [PORT_BITS-1:0] slot_port;
  logic                 slot_ok;
  logic [PORT_BITS-1:0] in_port;

  // learn and forget decisions
  logic                 set_slot;
  logic                 clr_slot;
  out_item_t            res;

  mlft_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // stored entry split
  assign slot_mac  = ram_rdata[EntW-1:PORT_BITS];
  assign slot_port = ram_rdata[PORT_BITS-1:0];
  assign slot_ok   = cmp_en_q && valid_q[rd_idx_q];
  assign in_port   = PORT_BITS'(32'(item_q.ingress_port));
  assign ram_wdata = {item_q.source_mac, in_port};
  assign ram_we    = cmd_i.commit && set_slot;

  // result of the finished scan
  always_comb begin
    set_slot = 1'b0;
    clr_slot = 1'b0;
    res      = '0;
    if (item_q.action == ActExpire) begin
      if (table_ready_i && src_hit_q) begin
        clr_slot    = 1'b1;
        res.removed = 1'b1;
      end
    end else if (!table_ready_i) begin
      res.flood        = 1'b1;
      res.learn_status = StNotReady;
    end else begin
      // destination lookup on the table before learning
      if (item_q.dest_mac != MacBcast && dst_hit_q) begin
        res.egress_port = ItemPortW'(32'(dst_port_q));
      end else begin
        res.flood = 1'b1;
      end
      // source learning
      priority if (item_q.source_mac == MacBcast) begin
        res.learn_status = StBcastSrc;
      end else if (src_hit_q) begin
        res.learn_status = (src_port_q == in_port) ? StSame : StConflict;
      end else if (free_hit_q) begin
        set_slot         = 1'b1;
        res.learn_status = StLearned;
      end else begin
        res.learn_status = StFull;
      end
    end
  end

  // next state of the datapath
  always_comb begin
    item_d      = item_q;
    cnt_d       = cnt_q;
    rd_idx_d    = cnt_q;
    cmp_en_d    = cmd_i.scan;
    dst_hit_d   = dst_hit_q;
    dst_port_d  = dst_port_q;
    src_hit_d   = src_hit_q;
    src_idx_d   = src_idx_q;
    src_port_d  = src_port_q;
    free_hit_d  = free_hit_q;
    free_idx_d  = free_idx_q;
    valid_d     = valid_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;

    // new item clears the scan
    if (cmd_i.load) begin
      item_d     = in_item_i;
      cnt_d      = '0;
      dst_hit_d  = 1'b0;
      src_hit_d  = 1'b0;
      free_hit_d = 1'b0;
    end

    // step the read address
    if (cmd_i.scan) begin
      cnt_d = cnt_q + 1'b1;
    end

    // compare the slot read last cycle, keep the lowest hit
    if (slot_ok && !dst_hit_q && slot_mac == item_q.dest_mac) begin
      dst_hit_d  = 1'b1;
      dst_port_d = slot_port;
    end
    if (slot_ok && !src_hit_q && slot_mac == item_q.source_mac) begin
      src_hit_d  = 1'b1;
      src_idx_d  = rd_idx_q;
      src_port_d = slot_port;
    end
    if (cmp_en_q && !valid_q[rd_idx_q] && !free_hit_q) begin
      free_hit_d = 1'b1;
      free_idx_d = rd_idx_q;
    end

    // commit the table update and load the result
    if (cmd_i.commit) begin
      if (set_slot) begin
        valid_d[free_idx_q] = 1'b1;
      end
      if (clr_slot) begin
        valid_d[src_idx_q] = 1'b0;
      end
      out_item_d  = res;
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      cmp_en_q    <= 1'b0;
      dst_hit_q   <= 1'b0;
      src_hit_q   <= 1'b0;
      src_idx_q   <= '0;
      free_hit_q  <= 1'b0;
      free_idx_q  <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      cmp_en_q    <= cmp_en_d;
      dst_hit_q   <= dst_hit_d;
      src_hit_q   <= src_hit_d;
      src_idx_q   <= src_idx_d;
      free_hit_q  <= free_hit_d;
      free_idx_q  <= free_idx_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    dst_port_q <= dst_port_d;
    src_port_q <= src_port_d;
    out_item_q <= out_item_d;
  end

  assign stat_o.scan_last = (cnt_q == LastIdx);
  assign stat_o.out_busy  = out_valid_q && out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_item_q;

endmodule

// ===== hw/rtl/mlft_chk.sv =====
// port-level checker for the mac learning forwarding table, with its bind
`timescale 1ns / 1ps

module mlft_chk import mlft_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_item_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic in_acc;
  logic cfg_wr0;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_wr0 = psel && penable && pwrite && pready && (paddr[2] == RegTableReady);

  // an accepted item holds off the next one while it is scanned
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // a result never appears the cycle right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result raised too early after accept");

  // a new result only comes out of a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while block was idle");

  // a waiting result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result dropped or changed");

  // a write to table_ready reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr0 ##1 (paddr[2] == RegTableReady) |-> (prdata[0] == $past(pwdata[0])))
    else $error("table_ready readback mismatch");

endmodule

bind mac_learning_forward_table_top mlft_chk u_mlft_chk (.*);
